// ===== sv/flow_table_hit_counter_defines.svh =====
// ---------------------------------------------------------------------------
// Flow table hit counter assertion macros
// Shared concurrent assertion forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef FLOW_TABLE_HIT_COUNTER_DEFINES_SVH
`define FLOW_TABLE_HIT_COUNTER_DEFINES_SVH

// same-cycle implication, reset-qualified
`define FTHC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset-qualified
`define FTHC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fthc_pkg.sv =====
// ---------------------------------------------------------------------------
// Flow table hit counter package
// Transaction payload types, sequencer states and fixed constants.
// ---------------------------------------------------------------------------
package fthc_pkg;

  localparam int unsigned KEY_W = 96;

  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
  localparam logic [31:0] HASH_SEED_RESET = 32'h0000_0001;
  localparam logic [31:0] COUNT_NEAR_MAX  = 32'hFFFF_FFFE;
  localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_ONE       = 32'h0000_0001;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } in_data_t;

  typedef struct packed {
    logic        flow_hit;
    logic        flow_inserted;
    logic        bucket_full;
    logic [3:0]  bucket_index;
    logic [3:0]  slot_index;
    logic [31:0] flow_count;
  } out_data_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_BASE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

// ===== sv/fthc_ram.sv =====
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module fthc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 192,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/flow_table_hit_counter.sv =====
// ---------------------------------------------------------------------------
// Flow table hit counter
// Bucketed hash table of flow keys with one hit counter per slot.
// Input transaction: one flow key (in_valid/in_ready/in_data). Output
// transaction: one result per key (out_valid/out_ready/out_data).
// Config: cfg_we/cfg_wdata write the CRC seed; write only while idle.
// After reset a clearing pass empties all BUCKET_COUNT * SLOTS_PER_BUCKET
// slots of the key store; in_ready is low.
// Each key goes through a byte-serial CRC, a bit-serial reduction modulo
// BUCKET_COUNT when BUCKET_COUNT is not a power of two, and a scan of the
// bucket one slot per cycle through the key and count RAM read ports.
// A new key is taken only in the idle state, after the last one finishes.
// A stalled result holds in the output register; the next key is taken and
// processed meanwhile, and its result waits until the register frees.
// ---------------------------------------------------------------------------
module flow_table_hit_counter #(
  parameter int unsigned BUCKET_COUNT     = 16,
  parameter int unsigned SLOTS_PER_BUCKET = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fthc_pkg::in_data_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fthc_pkg::out_data_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);

  localparam int unsigned TOTAL   = BUCKET_COUNT * SLOTS_PER_BUCKET;
  localparam int unsigned AW      = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int unsigned BW      = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned SW      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int unsigned SCW     = $clog2(SLOTS_PER_BUCKET + 1);
  localparam bit          IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
  localparam int unsigned KW      = fthc_pkg::KEY_W;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ fthc_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] next_count(input logic [31:0] old);
    if (old == fthc_pkg::COUNT_NEAR_MAX || old == fthc_pkg::COUNT_MAX) begin
      return fthc_pkg::COUNT_ONE;
    end
    return old + 32'd1;
  endfunction

  fthc_pkg::state_t    state_r, state_nxt;
  logic [31:0]         seed_r, seed_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [31:0]         crc_r, crc_nxt;
  logic [4:0]          step_cnt_r, step_cnt_nxt;
  logic [BW-1:0]       rem_r, rem_nxt;
  logic [BW-1:0]       bucket_r, bucket_nxt;
  logic [AW-1:0]       base_r, base_nxt;
  logic [SCW-1:0]      issue_cnt_r, issue_cnt_nxt;
  logic                cmp_valid_r, cmp_valid_nxt;
  logic [SW-1:0]       cmp_slot_r, cmp_slot_nxt;
  logic [AW-1:0]       cmp_addr_r, cmp_addr_nxt;
  logic                hit_r, hit_nxt;
  logic                free_r, free_nxt;
  logic [SW-1:0]       first_free_r, first_free_nxt;
  logic [SW-1:0]       last_slot_r, last_slot_nxt;
  logic [31:0]         last_count_r, last_count_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  fthc_pkg::out_data_t out_data_r, out_data_nxt;

  logic                key_we;
  logic [AW-1:0]       key_waddr;
  logic [KW-1:0]       key_wdata;
  logic [KW-1:0]       key_rdata;
  logic                cnt_we;
  logic [AW-1:0]       cnt_waddr;
  logic [31:0]         cnt_wdata;
  logic [31:0]         cnt_rdata;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       ins_addr;
  logic [BW:0]         rem_shift;
  logic [BW-1:0]       bucket_sel;
  logic                out_free;
  logic                do_insert;

  fthc_ram #(.WIDTH(KW), .DEPTH(TOTAL)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  fthc_ram #(.WIDTH(32), .DEPTH(TOTAL)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (cnt_rdata)
  );

  assign rd_addr    = base_r + AW'(issue_cnt_r);
  assign ins_addr   = base_r + AW'(first_free_r);
  assign rem_shift  = {rem_r, crc_r[31]};
  assign bucket_sel = IS_POW2 ? (BW'(crc_r) & BW'(BUCKET_COUNT - 1)) : rem_r;
  assign out_free   = !out_valid_r || out_ready;
  assign do_insert  = !hit_r && free_r;

  always_comb begin
    state_nxt      = state_r;
    seed_nxt       = cfg_we ? cfg_wdata : seed_r;
    key_nxt        = key_r;
    crc_nxt        = crc_r;
    step_cnt_nxt   = step_cnt_r;
    rem_nxt        = rem_r;
    bucket_nxt     = bucket_r;
    base_nxt       = base_r;
    issue_cnt_nxt  = issue_cnt_r;
    cmp_valid_nxt  = 1'b0;
    cmp_slot_nxt   = cmp_slot_r;
    cmp_addr_nxt   = cmp_addr_r;
    hit_nxt        = hit_r;
    free_nxt       = free_r;
    first_free_nxt = first_free_r;
    last_slot_nxt  = last_slot_r;
    last_count_nxt = last_count_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    in_ready       = 1'b0;
    rd_en          = 1'b0;
    key_we         = 1'b0;
    key_waddr      = clr_cnt_r;
    key_wdata      = '0;
    cnt_we         = 1'b0;
    cnt_waddr      = cmp_addr_r;
    cnt_wdata      = next_count(cnt_rdata);

    unique case (state_r)
      fthc_pkg::S_CLEAR: begin
        key_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(TOTAL - 1)) begin
          state_nxt = fthc_pkg::S_IDLE;
        end
      end
      fthc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt      = {in_data.src_addr, in_data.dst_addr,
                          in_data.src_port, in_data.dst_port};
          crc_nxt      = seed_r;
          step_cnt_nxt = '0;
          state_nxt    = fthc_pkg::S_HASH;
        end
      end
      fthc_pkg::S_HASH: begin
        crc_nxt      = crc_byte(crc_r, key_r[8 * (11 - int'(step_cnt_r)) +: 8]);
        step_cnt_nxt = step_cnt_r + 5'd1;
        if (step_cnt_r == 5'd11) begin
          step_cnt_nxt = '0;
          rem_nxt      = '0;
          state_nxt    = IS_POW2 ? fthc_pkg::S_BASE : fthc_pkg::S_MOD;
        end
      end
      fthc_pkg::S_MOD: begin
        rem_nxt      = BW'((rem_shift >= (BW + 1)'(BUCKET_COUNT)) ?
                           rem_shift - (BW + 1)'(BUCKET_COUNT) : rem_shift);
        crc_nxt      = crc_r << 1;
        step_cnt_nxt = step_cnt_r + 5'd1;
        if (step_cnt_r == 5'd31) begin
          state_nxt = fthc_pkg::S_BASE;
        end
      end
      fthc_pkg::S_BASE: begin
        bucket_nxt    = bucket_sel;
        base_nxt      = AW'(bucket_sel) * AW'(SLOTS_PER_BUCKET);
        issue_cnt_nxt = '0;
        hit_nxt       = 1'b0;
        free_nxt      = 1'b0;
        first_free_nxt = '0;
        last_slot_nxt = '0;
        last_count_nxt = '0;
        state_nxt     = fthc_pkg::S_SCAN;
      end
      fthc_pkg::S_SCAN: begin
        if (issue_cnt_r < SCW'(SLOTS_PER_BUCKET)) begin
          rd_en         = 1'b1;
          issue_cnt_nxt = issue_cnt_r + SCW'(1);
          cmp_valid_nxt = 1'b1;
          cmp_slot_nxt  = SW'(issue_cnt_r);
          cmp_addr_nxt  = rd_addr;
        end
        if (cmp_valid_r) begin
          if (key_rdata[KW-1 -: 32] == 32'd0) begin
            if (!free_r) begin
              free_nxt       = 1'b1;
              first_free_nxt = cmp_slot_r;
            end
          end else if (key_rdata == key_r) begin
            cnt_we         = 1'b1;
            hit_nxt        = 1'b1;
            last_slot_nxt  = cmp_slot_r;
            last_count_nxt = cnt_wdata;
          end
        end
        if (issue_cnt_r == SCW'(SLOTS_PER_BUCKET) && !cmp_valid_r) begin
          state_nxt = fthc_pkg::S_FINISH;
        end
      end
      fthc_pkg::S_FINISH: begin
        if (out_free) begin
          key_we                     = do_insert;
          key_waddr                  = ins_addr;
          key_wdata                  = key_r;
          cnt_we                     = do_insert;
          cnt_waddr                  = ins_addr;
          cnt_wdata                  = fthc_pkg::COUNT_ONE;
          out_valid_nxt              = 1'b1;
          out_data_nxt.flow_hit      = hit_r;
          out_data_nxt.flow_inserted = do_insert;
          out_data_nxt.bucket_full   = !hit_r && !free_r;
          out_data_nxt.bucket_index  = 4'(bucket_r);
          out_data_nxt.slot_index    = hit_r ? 4'(last_slot_r) :
                                       do_insert ? 4'(first_free_r) : 4'd0;
          out_data_nxt.flow_count    = hit_r ? last_count_r :
                                       do_insert ? fthc_pkg::COUNT_ONE : 32'd0;
          state_nxt                  = fthc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fthc_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fthc_pkg::S_CLEAR;
      seed_r      <= fthc_pkg::HASH_SEED_RESET;
      clr_cnt_r   <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    crc_r        <= crc_nxt;
    step_cnt_r   <= step_cnt_nxt;
    rem_r        <= rem_nxt;
    bucket_r     <= bucket_nxt;
    base_r       <= base_nxt;
    issue_cnt_r  <= issue_cnt_nxt;
    cmp_slot_r   <= cmp_slot_nxt;
    cmp_addr_r   <= cmp_addr_nxt;
    hit_r        <= hit_nxt;
    free_r       <= free_nxt;
    first_free_r <= first_free_nxt;
    last_slot_r  <= last_slot_nxt;
    last_count_r <= last_count_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/fthc_checker.sv =====
// ---------------------------------------------------------------------------
// Flow table hit counter port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
`include "flow_table_hit_counter_defines.svh"

module fthc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fthc_pkg::out_data_t out_data
);

  `FTHC_ASSERT_NXT(a_out_hold, clk, !rst_n,
                   rst_n && out_valid && !out_ready,
                   out_valid && $stable(out_data),
                   "stalled result transaction changed")
  `FTHC_ASSERT_IMP(a_one_outcome, clk, !rst_n, out_valid,
                   $onehot({out_data.flow_hit, out_data.flow_inserted, out_data.bucket_full}),
                   "result must be exactly one of hit, insert, full")
  `FTHC_ASSERT_IMP(a_full_zero, clk, !rst_n, out_valid && out_data.bucket_full,
                   out_data.slot_index == 4'd0 && out_data.flow_count == 32'd0,
                   "full bucket must report zero slot and count")
  `FTHC_ASSERT_IMP(a_count_nz, clk, !rst_n, out_valid && !out_data.bucket_full,
                   out_data.flow_count != 32'd0 &&
                   (out_data.flow_hit || out_data.flow_count == 32'd1),
                   "hit count zero or insert count not one")
  `FTHC_ASSERT_NXT(a_busy, clk, !rst_n, rst_n && in_valid && in_ready, !in_ready,
                   "input transaction taken while busy")

endmodule

bind flow_table_hit_counter fthc_checker u_fthc_checker (.*);
